// ----- rtl/lfhp_pkg.sv -----
// Frame header parser package: phase codes, result kinds, error codes,
// the result item type and the header decode functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfhp_pkg;

   // Parse phases: idle, one per header byte position after the first, and payload
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_DMAC = 4'd1,
      PH_LEN  = 4'd2,
      PH_HDR  = 4'd3,
      PH_SNET = 4'd4,
      PH_SMAC = 4'd5,
      PH_DNET = 4'd6,
      PH_DADR = 4'd7,
      PH_SEQ  = 4'd8,
      PH_SP0  = 4'd9,
      PH_SP1  = 4'd10,
      PH_DP0  = 4'd11,
      PH_DP1  = 4'd12,
      PH_PAY  = 4'd13
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes carried in the value field
   localparam logic [7:0] ERR_LEVEL    = 8'd0;
   localparam logic [7:0] ERR_ZERO_LEN = 8'd1;
   localparam logic [7:0] ERR_OVERRUN  = 8'd2;

   // Header byte: level bits 7:6 must read binary 10
   localparam logic [7:0] LEVEL_MASK = 8'hc0;
   localparam logic [7:0] LEVEL_OK   = 8'h80;

   // Configuration registers
   localparam logic       REG_DEFAULT_PORT   = 1'b0;
   localparam logic [15:0] DEFAULT_PORT_RESET = 16'hcdcd;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  src_mac;
      logic [7:0]  dst_mac;
      logic [1:0]  multi_mode;
      logic [15:0] orig_addr;
      logic [15:0] dest_addr;
      logic        seq_present;
      logic [6:0]  seq_num;
      logic        req_ack;
      logic [15:0] orig_port;
      logic [15:0] dest_port;
      logic [7:0]  value;
   } rsp_item_type;

   // Source port byte count by size code
   function automatic logic [1:0] orig_port_bytes(input logic [2:0] code);
      case (code)
         3'd0, 3'd1:        orig_port_bytes = 2'd0;
         3'd2, 3'd4, 3'd5:  orig_port_bytes = 2'd1;
         default:           orig_port_bytes = 2'd2;
      endcase
   endfunction

   // Destination port byte count by size code
   function automatic logic [1:0] dest_port_bytes(input logic [2:0] code);
      case (code)
         3'd2, 3'd3:        dest_port_bytes = 2'd0;
         3'd0, 3'd4, 3'd6:  dest_port_bytes = 2'd1;
         default:           dest_port_bytes = 2'd2;
      endcase
   endfunction

   // Whether an optional header phase is present for this header byte
   function automatic logic phase_needed(input phase_type ph, input logic [7:0] hdr);
      logic [1:0] ss;
      logic [1:0] ds;
      ss = orig_port_bytes(hdr[2:0]);
      ds = dest_port_bytes(hdr[2:0]);
      case (ph)
         PH_SNET, PH_SMAC: phase_needed = hdr[5];
         PH_DNET, PH_DADR: phase_needed = (hdr[5:4] != 2'd0);
         PH_SEQ:           phase_needed = hdr[3];
         PH_SP0:           phase_needed = (ss != 2'd0);
         PH_SP1:           phase_needed = (ss == 2'd2);
         PH_DP0:           phase_needed = (ds != 2'd0);
         PH_DP1:           phase_needed = (ds == 2'd2);
         default:          phase_needed = 1'b0;
      endcase
   endfunction

   // First present header phase after ph, or payload when none is left
   function automatic phase_type next_phase(input phase_type ph, input logic [7:0] hdr);
      logic found;
      found      = 1'b0;
      next_phase = PH_PAY;
      for (int q = 4; q <= 12; q++) begin
         if (!found && (q[3:0] > ph) && phase_needed(phase_type'(q[3:0]), hdr)) begin
            next_phase = phase_type'(q[3:0]);
            found      = 1'b1;
         end
      end
   endfunction

   // Header length in bytes, header byte included
   function automatic logic [3:0] header_length(input logic [7:0] hdr);
      header_length = 4'd1
                    + (hdr[5:4] != 2'd0 ? 4'd2 : 4'd0)
                    + (hdr[5] ? 4'd2 : 4'd0)
                    + {3'd0, hdr[3]}
                    + {2'd0, orig_port_bytes(hdr[2:0])}
                    + {2'd0, dest_port_bytes(hdr[2:0])};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lfhp_csr.sv -----
// Configuration register file: the default port register on an APB-style port.
// Depends on lfhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfhp_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [15:0]      default_port
);

   logic [15:0] default_port_ff;
   logic [15:0] default_port_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready
                & (csr_paddr[2] == lfhp_pkg::REG_DEFAULT_PORT);

   // register write
   always_comb begin
      default_port_in = default_port_ff;
      if (wr_en) begin
         default_port_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_port_ff <= lfhp_pkg::DEFAULT_PORT_RESET;
      end else begin
         default_port_ff <= default_port_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == lfhp_pkg::REG_DEFAULT_PORT) begin
         csr_prdata = {16'd0, default_port_ff};
      end
   end

   assign default_port = default_port_ff;

endmodule

`default_nettype wire

// ----- rtl/lfhp_parse.sv -----
// Byte-at-a-time frame parser: phase register, held header fields and the
// single-pass decode that forms at most one result item per accepted byte.
// Depends on lfhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfhp_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 frame_start,
   input  wire logic [15:0]          default_port,
   output logic                      res_valid,
   output lfhp_pkg::rsp_item_type    res_item
);

   lfhp_pkg::phase_type phase_ff, phase_in, nxt;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  src_mac_ff, src_mac_in;
   logic [7:0]  dst_mac_ff, dst_mac_in;
   logic [15:0] orig_addr_ff, orig_addr_in;
   logic [15:0] dest_addr_ff, dest_addr_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] orig_port_ff, orig_port_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic        consume;
   logic [3:0]  hlen;

   assign hlen = lfhp_pkg::header_length(data_byte);

   // next state and result for the accepted byte
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      header_in    = header_ff;
      src_mac_in   = src_mac_ff;
      dst_mac_in   = dst_mac_ff;
      orig_addr_in = orig_addr_ff;
      dest_addr_in = dest_addr_ff;
      seq_in       = seq_ff;
      orig_port_in = orig_port_ff;
      dest_port_in = dest_port_ff;
      consume      = 1'b0;
      res_valid    = 1'b0;
      res_item     = '0;
      nxt          = lfhp_pkg::PH_IDLE;

      if (!accept) begin
         consume = 1'b0;
      end else if (frame_start) begin
         // frame start always restarts, whatever was in progress
         src_mac_in = data_byte;
         phase_in   = lfhp_pkg::PH_DMAC;
      end else begin
         case (phase_ff)
            lfhp_pkg::PH_IDLE: begin
               phase_in = lfhp_pkg::PH_IDLE;
            end
            lfhp_pkg::PH_DMAC: begin
               dst_mac_in = data_byte;
               phase_in   = lfhp_pkg::PH_LEN;
            end
            lfhp_pkg::PH_LEN: begin
               if (data_byte == 8'd0) begin
                  res_valid      = 1'b1;
                  res_item.kind  = lfhp_pkg::KIND_ERROR;
                  res_item.value = lfhp_pkg::ERR_ZERO_LEN;
                  phase_in       = lfhp_pkg::PH_IDLE;
               end else begin
                  remaining_in = data_byte;
                  phase_in     = lfhp_pkg::PH_HDR;
               end
            end
            lfhp_pkg::PH_HDR: begin
               header_in = data_byte;
               if ((data_byte & lfhp_pkg::LEVEL_MASK) != lfhp_pkg::LEVEL_OK) begin
                  res_valid      = 1'b1;
                  res_item.kind  = lfhp_pkg::KIND_ERROR;
                  res_item.value = lfhp_pkg::ERR_LEVEL;
                  phase_in       = lfhp_pkg::PH_IDLE;
               end else if ({4'd0, hlen} > remaining_ff) begin
                  res_valid      = 1'b1;
                  res_item.kind  = lfhp_pkg::KIND_ERROR;
                  res_item.value = lfhp_pkg::ERR_OVERRUN;
                  phase_in       = lfhp_pkg::PH_IDLE;
               end else begin
                  orig_addr_in = 16'd0;
                  dest_addr_in = 16'd0;
                  seq_in       = 8'd0;
                  orig_port_in = 16'd0;
                  dest_port_in = 16'd0;
                  consume      = 1'b1;
               end
            end
            lfhp_pkg::PH_SNET: begin
               orig_addr_in = {data_byte, 8'h00};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_SMAC: begin
               orig_addr_in = {orig_addr_ff[15:8], data_byte};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_DNET: begin
               dest_addr_in = {data_byte, 8'h00};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_DADR: begin
               dest_addr_in = {dest_addr_ff[15:8], data_byte};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_SEQ: begin
               seq_in  = data_byte;
               consume = 1'b1;
            end
            lfhp_pkg::PH_SP0: begin
               orig_port_in = {8'h00, data_byte};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_SP1: begin
               orig_port_in = {data_byte, orig_port_ff[7:0]};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_DP0: begin
               dest_port_in = {8'h00, data_byte};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_DP1: begin
               dest_port_in = {data_byte, dest_port_ff[7:0]};
               consume      = 1'b1;
            end
            lfhp_pkg::PH_PAY: begin
               remaining_in   = remaining_ff - 8'd1;
               res_valid      = 1'b1;
               res_item.kind  = lfhp_pkg::KIND_PAYLOAD;
               res_item.value = data_byte;
               if (remaining_in == 8'd0) begin
                  phase_in = lfhp_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = lfhp_pkg::PH_IDLE;
            end
         endcase
      end

      // a header byte was taken: step to the next present field
      if (consume) begin
         remaining_in = remaining_ff - 8'd1;
         nxt          = lfhp_pkg::next_phase(phase_ff, header_in);
         phase_in     = nxt;
         if (nxt == lfhp_pkg::PH_PAY) begin
            res_valid            = 1'b1;
            res_item.kind        = lfhp_pkg::KIND_HEADER;
            res_item.src_mac     = src_mac_in;
            res_item.dst_mac     = dst_mac_in;
            res_item.multi_mode  = header_in[5:4];
            res_item.orig_addr   = header_in[5] ? orig_addr_in : 16'd0;
            res_item.dest_addr   = (header_in[5:4] != 2'd0) ? dest_addr_in : 16'd0;
            res_item.seq_present = header_in[3];
            res_item.seq_num     = header_in[3] ? seq_in[6:0] : 7'd0;
            res_item.req_ack     = header_in[3] ? seq_in[7] : 1'b0;
            res_item.orig_port   = (lfhp_pkg::orig_port_bytes(header_in[2:0]) != 2'd0)
                                 ? orig_port_in : default_port;
            res_item.dest_port   = (lfhp_pkg::dest_port_bytes(header_in[2:0]) != 2'd0)
                                 ? dest_port_in : default_port;
            res_item.value       = remaining_in;
            phase_in = (remaining_in != 8'd0) ? lfhp_pkg::PH_PAY : lfhp_pkg::PH_IDLE;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lfhp_pkg::PH_IDLE;
         remaining_ff <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   // held header fields
   always_ff @(posedge clock) begin
      header_ff    <= header_in;
      src_mac_ff   <= src_mac_in;
      dst_mac_ff   <= dst_mac_in;
      orig_addr_ff <= orig_addr_in;
      dest_addr_ff <= dest_addr_in;
      seq_ff       <= seq_in;
      orig_port_ff <= orig_port_in;
      dest_port_ff <= dest_port_in;
   end

endmodule

`default_nettype wire

// ----- rtl/lfhp_skid.sv -----
// Result register with a skid entry; keeps the input ready registered so
// the two sides of the block are parted.
// Depends on lfhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfhp_skid (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  wire lfhp_pkg::rsp_item_type push_item,
   output logic                        push_ready,
   output logic                        out_valid,
   output lfhp_pkg::rsp_item_type      out_item,
   input  wire logic                   out_ready
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   lfhp_pkg::rsp_item_type main_item_ff, main_item_in;
   lfhp_pkg::rsp_item_type skid_item_ff, skid_item_in;
   logic                   pop;

   assign pop        = main_valid_ff & out_ready;
   assign push_ready = ~skid_valid_ff;

   // main and skid entry update
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_item_in  = main_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff || pop) begin
            main_item_in  = push_item;
            main_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign out_valid = main_valid_ff;
   assign out_item  = main_item_ff;

endmodule

`default_nettype wire

// ----- rtl/l1_frame_header_parser_core.sv -----
// Frame header parser top level: stream in, stream out, configuration port.
// Depends on lfhp_pkg, lfhp_csr, lfhp_parse and lfhp_skid.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one frame byte per cycle on the req_ stream, with
// req_tuser marking the first byte of a frame, and keeps taking a byte every
// cycle as long as the rsp_ side drains. Each byte is decoded in a single
// pass against the current parse phase; a header, payload or error item
// is registered in the result register, or in the skid entry if that is held.
// A two-entry result stage (result register plus skid entry) keeps req_tready
// registered; it drops only when both entries hold items the consumer has not
// taken. A byte that causes no item is accepted just the same. The default
// port register is read at the moment a header item is formed, so it should
// be written only while no frame is in flight.

module l1_frame_header_parser_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // input stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] frame_start
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // [7:0] src_mac, [15:8] dst_mac,
                                          // [17:16] multi_mode, [33:18] orig_addr,
                                          // [49:34] dest_addr, [50] seq_present,
                                          // [57:51] seq_num, [58] req_ack,
                                          // [74:59] orig_port, [90:75] dest_port,
                                          // [98:91] value, [103:99] zero
   output logic [1:0]        rsp_tuser,   // [1:0] kind
   // configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic                   accept;
   logic [15:0]            default_port;
   logic                   res_valid;
   lfhp_pkg::rsp_item_type res_item;
   lfhp_pkg::rsp_item_type out_item;

   assign accept = req_tvalid & req_tready;

   lfhp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .default_port (default_port)
   );

   lfhp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .frame_start  (req_tuser),
      .default_port (default_port),
      .res_valid    (res_valid),
      .res_item     (res_item)
   );

   lfhp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept & res_valid),
      .push_item  (res_item),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_item   (out_item),
      .out_ready  (rsp_tready)
   );

   // pack the result item onto the stream
   assign rsp_tuser = out_item.kind;
   assign rsp_tdata = {5'd0,
                       out_item.value,
                       out_item.dest_port,
                       out_item.orig_port,
                       out_item.req_ack,
                       out_item.seq_num,
                       out_item.seq_present,
                       out_item.dest_addr,
                       out_item.orig_addr,
                       out_item.multi_mode,
                       out_item.dst_mac,
                       out_item.src_mac};

endmodule

`default_nettype wire
